// ===== rtl/cisq_pkg.sv =====
package cisq_pkg;

    // per-slot phase, one-hot
    typedef enum logic [2:0] {
        PHASE_IDLE  = 3'b001,
        PHASE_CHECK = 3'b010,
        PHASE_READY = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] deadline;
        logic        armed;
    } slot_state_t;

    // request operation codes
    localparam logic OP_POLL  = 1'b0;
    localparam logic OP_RESET = 1'b1;

    localparam logic [7:0]  CIS_TUPLE_MARK     = 8'h1d;
    localparam logic [15:0] SETTLE_RESET       = 16'd50;
    localparam int          SLOT_COUNT_DEFAULT = 2;

    localparam slot_state_t SLOT_CLEARED = '{
        phase:    PHASE_IDLE,
        deadline: 32'd0,
        armed:    1'b0
    };

endpackage

// ===== rtl/cisq_slot_update.sv =====
module cisq_slot_update
    import cisq_pkg::*;
(
    input  slot_state_t  cur_state,
    input  logic         in_range,
    input  logic         operation,
    input  logic         card_detect,
    input  logic [7:0]   cis_byte,
    input  logic [31:0]  now_ticks,
    input  logic [15:0]  settle_ticks,
    output slot_state_t  nxt_state,
    output logic         card_present,
    output logic         card_ready
);

    logic [31:0] arm_deadline;
    logic [31:0] deadline_diff;
    logic        deadline_passed;
    phase_t      ph;
    logic [31:0] dl;
    logic        arm;

    assign arm_deadline    = now_ticks + {16'd0, settle_ticks};
    assign deadline_diff   = cur_state.deadline - now_ticks;
    // wrap-safe: now strictly after deadline
    assign deadline_passed = deadline_diff[31];

    always_comb
    begin
        nxt_state    = cur_state;
        card_present = 1'b0;
        card_ready   = 1'b0;
        ph           = cur_state.phase;
        dl           = cur_state.deadline;
        arm          = cur_state.armed;
        if (in_range)
        begin
            if (operation == OP_RESET)
            begin
                if (card_detect)
                begin
                    nxt_state = SLOT_CLEARED;
                end
            end
            else if (!card_detect)
            begin
                nxt_state = SLOT_CLEARED;
            end
            else
            begin
                if (ph == PHASE_IDLE)
                begin
                    if (!arm)
                    begin
                        dl  = arm_deadline;
                        arm = 1'b1;
                    end
                    else if (deadline_passed)
                    begin
                        ph = PHASE_CHECK;
                    end
                end
                // check resolves within the same poll
                if (ph == PHASE_CHECK)
                begin
                    if (cis_byte == CIS_TUPLE_MARK)
                    begin
                        ph = PHASE_READY;
                    end
                    else
                    begin
                        ph  = PHASE_IDLE;
                        dl  = 32'd0;
                        arm = 1'b0;
                    end
                end
                nxt_state    = '{phase: ph, deadline: dl, armed: arm};
                card_present = 1'b1;
                card_ready   = (ph == PHASE_READY);
            end
        end
    end

endmodule

// ===== rtl/ci_slot_insertion_qualifier.sv =====
// Card slot insertion qualifier.
//
// Input channel (in_valid/in_ready): one request per poll or slot reset,
// carrying operation, slot, card_detect, cis_byte and now_ticks.
// Output channel (out_valid/out_ready): exactly one result per request,
// card_present and card_ready, in request order.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes settle_ticks;
// cfg_ready is always high. Write it only while no request is in flight.
//
// When the output is free, a request accepted into the input register
// passes through the per-slot update into the result register, which
// raises out_valid. Throughput: one request per cycle while the receiver
// does not stall; the per-slot state update is one pass through a 32-bit
// add/subtract and a compare, so back-to-back requests to the same slot
// see each other's effects.
// Reset: all slots go idle and disarmed, settle_ticks returns to 50,
// no result is pending. When the receiver stalls, the result register
// holds, one more request may wait in the input register, then in_ready
// drops until out_ready returns.
module ci_slot_insertion_qualifier
    import cisq_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic        slot,
    input  logic        card_detect,
    input  logic [7:0]  cis_byte,
    input  logic [31:0] now_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        card_present,
    output logic        card_ready
);

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [15:0] settle_ticks_reg;

    // input register
    logic        s1_valid_reg;
    logic        s1_operation_reg;
    logic        s1_slot_reg;
    logic        s1_card_detect_reg;
    logic [7:0]  s1_cis_byte_reg;
    logic [31:0] s1_now_ticks_reg;

    // result register
    logic        out_valid_reg;
    logic        card_present_reg;
    logic        card_ready_reg;

    slot_state_t slot_state_reg [SLOT_COUNT];

    logic                  advance;
    logic                  in_range;
    logic [SLOT_IDX_W-1:0] slot_idx;
    slot_state_t           cur_state;
    slot_state_t           nxt_state;
    logic                  res_present;
    logic                  res_ready;

    assign cfg_ready = 1'b1;
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;

    // slot field may exceed the number of slots built
    assign in_range  = (32'(s1_slot_reg) < SLOT_COUNT);
    assign slot_idx  = in_range ? SLOT_IDX_W'(s1_slot_reg) : '0;
    assign cur_state = slot_state_reg[slot_idx];

    cisq_slot_update u_update (
        .cur_state    (cur_state),
        .in_range     (in_range),
        .operation    (s1_operation_reg),
        .card_detect  (s1_card_detect_reg),
        .cis_byte     (s1_cis_byte_reg),
        .now_ticks    (s1_now_ticks_reg),
        .settle_ticks (settle_ticks_reg),
        .nxt_state    (nxt_state),
        .card_present (res_present),
        .card_ready   (res_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ticks_reg <= SETTLE_RESET;
        end
        else if (cfg_valid)
        begin
            settle_ticks_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_operation_reg   <= operation;
            s1_slot_reg        <= slot;
            s1_card_detect_reg <= card_detect;
            s1_cis_byte_reg    <= cis_byte;
            s1_now_ticks_reg   <= now_ticks;
        end
    end

    // per-slot state, written when the request in the input register retires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_state_reg[i] <= SLOT_CLEARED;
            end
        end
        else if (advance && in_range)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (slot_idx == SLOT_IDX_W'(i))
                begin
                    slot_state_reg[i] <= nxt_state;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            card_present_reg <= res_present;
            card_ready_reg   <= res_ready;
        end
    end

    assign out_valid    = out_valid_reg;
    assign card_present = card_present_reg;
    assign card_ready   = card_ready_reg;

endmodule

// ===== rtl/cisq_checker.sv =====
module cisq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        card_present,
    input logic        card_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(card_present)
            && $stable(card_ready))
        else $error("stalled result changed or dropped");

    // ready slot is always a present card
    a_ready_present: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !card_ready || card_present)
        else $error("card_ready without card_present");

    // a new result follows an accepted request through the input and result registers
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching request");

    // input backpressure only from a stalled output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low while output is free");

endmodule

bind ci_slot_insertion_qualifier cisq_checker u_cisq_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import cisq_pkg::*;

    localparam int SLOT_COUNT   = SLOT_COUNT_DEFAULT;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the block
    localparam int DRAIN_PAUSE  = 8;     // pause after each drain, with margin
    localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake at all

    // one request as the sender sees it, plus the gap that follows it
    typedef struct {
        logic        op;
        logic        slot;
        logic        card;
        logic [7:0]  cis;
        logic [31:0] now;
        int unsigned gap;
    } slot_req_t;

    typedef struct packed {
        logic present;
        logic ready;
    } slot_status_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        operation   = OP_POLL;
    logic        slot        = 1'b0;
    logic        card_detect = 1'b0;
    logic [7:0]  cis_byte    = '0;
    logic [31:0] now_ticks   = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        card_present;
    logic        card_ready;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ci_slot_insertion_qualifier #(
        .SLOT_COUNT(SLOT_COUNT)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .slot        (slot),
        .card_detect (card_detect),
        .cis_byte    (cis_byte),
        .now_ticks   (now_ticks),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .card_present(card_present),
        .card_ready  (card_ready)
    );

    // ------------------------------------------------------------------
    // Shared state between stimulus, driver, receiver and scoreboard
    // ------------------------------------------------------------------
    slot_req_t    poll_queue[$];          // requests waiting for the driver
    slot_req_t    slot_plan[2][$];        // per-slot sequences before interleaving
    slot_status_t expected_status[$];     // predicted results, oldest first
    logic [31:0]  slot_clock[2];          // tick base used to build each slot's sequences

    int unsigned  issued_total   = 0;
    int unsigned  accepted_total = 0;
    int unsigned  mismatch_count = 0;

    bit           recv_eager  = 1'b0;     // receiver takes every result at once
    int unsigned  holds_asked = 0;        // bumped by stimulus to ask for a long hold-off

    // ------------------------------------------------------------------
    // Slot qualification predictor: own copy of the register and state
    // ------------------------------------------------------------------
    logic [15:0] settle_model;
    phase_t      model_phase   [SLOT_COUNT];
    logic [31:0] model_deadline[SLOT_COUNT];
    logic        model_armed   [SLOT_COUNT];

    function automatic void clear_model_slot(input logic s);
        model_phase[s]    = PHASE_IDLE;
        model_deadline[s] = '0;
        model_armed[s]    = 1'b0;
    endfunction

    function automatic void reset_model();
        settle_model = SETTLE_RESET;
        for (int s = 0; s < SLOT_COUNT; s++)
            clear_model_slot(1'(s));
    endfunction

    function automatic slot_status_t qualify_req(input slot_req_t r);
        slot_status_t res;
        logic [31:0]  remaining;
        res.present = 1'b0;
        res.ready   = 1'b0;
        if (int'(r.slot) >= SLOT_COUNT)
            return res;
        // reset request: clears only when a card sits in the slot
        if (r.op == OP_RESET)
        begin
            if (r.card)
                clear_model_slot(r.slot);
            return res;
        end
        // poll with no card: slot is emptied
        if (!r.card)
        begin
            clear_model_slot(r.slot);
            return res;
        end
        if (model_phase[r.slot] == PHASE_IDLE)
        begin
            // wrap-safe: deadline passed when (deadline - now) is negative
            remaining = model_deadline[r.slot] - r.now;
            if (!model_armed[r.slot])
            begin
                model_deadline[r.slot] = r.now + 32'(settle_model);
                model_armed[r.slot]    = 1'b1;
            end
            else if (remaining[31])
                model_phase[r.slot] = PHASE_CHECK;
        end
        // checking resolves in the same poll: tuple mark or back to idle
        if (model_phase[r.slot] == PHASE_CHECK)
        begin
            if (r.cis == CIS_TUPLE_MARK)
                model_phase[r.slot] = PHASE_READY;
            else
                clear_model_slot(r.slot);
        end
        res.present = 1'b1;
        res.ready   = (model_phase[r.slot] == PHASE_READY);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued requests, random gap after each one
    // ------------------------------------------------------------------
    int unsigned send_wait = 0;

    always @(posedge clk or negedge rst_n)
    begin : sender
        slot_req_t req;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            send_wait <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (send_wait != 0)
            begin
                in_valid  <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (poll_queue.size() != 0)
            begin
                req = poll_queue.pop_front();
                in_valid    <= 1'b1;
                operation   <= req.op;
                slot        <= req.slot;
                card_detect <= req.card;
                cis_byte    <= req.cis;
                now_ticks   <= req.now;
                send_wait   <= req.gap;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall after each result (none when eager), plus long hold-offs on demand
    // ------------------------------------------------------------------
    int unsigned recv_wait    = 0;
    int unsigned hold_left    = 0;
    int unsigned holds_served = 0;

    always @(posedge clk or negedge rst_n)
    begin : receiver
        int unsigned draw;
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            recv_wait    <= 0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else if (holds_served != holds_asked)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            out_ready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            draw = recv_eager ? 0 : $urandom_range(0, 7);
            recv_wait <= draw;
            out_ready <= (draw == 0);
        end
        else if (recv_wait != 0)
        begin
            recv_wait <= recv_wait - 1;
            out_ready <= (recv_wait == 1);
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Scoreboard: predict on request accept, compare on result accept
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        slot_req_t    seen;
        slot_status_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                seen.op   = operation;
                seen.slot = slot;
                seen.card = card_detect;
                seen.cis  = cis_byte;
                seen.now  = now_ticks;
                seen.gap  = 0;
                expected_status.push_back(qualify_req(seen));
                accepted_total++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_status.size() == 0)
                begin
                    $error("result with no request outstanding: card_present %0b card_ready %0b",
                           card_present, card_ready);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (card_present !== want.present)
                    begin
                        $error("card_present: expected %0b, got %0b", want.present, card_present);
                        mismatch_count++;
                    end
                    if (card_ready !== want.ready)
                    begin
                        $error("card_ready: expected %0b, got %0b", want.ready, card_ready);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake on any channel counts as progress
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic plan_req(input logic s, input logic op, input logic card,
                            input logic [7:0] cis, input logic [31:0] now);
        slot_req_t r;
        r.op   = op;
        r.slot = s;
        r.card = card;
        r.cis  = cis;
        r.now  = now;
        r.gap  = 0;
        slot_plan[s].push_back(r);
    endtask

    // One insertion: arm, settle polls, the qualifying poll, ready polls, then
    // usually removal or slot reset. About one in ten is cut short mid-settle.
    task automatic plan_insertion(input logic s, input logic [15:0] st);
        logic [31:0] t;
        logic [31:0] due;
        logic [31:0] pass_at;
        logic [7:0]  mark;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            t = slot_clock[s] + $urandom_range(0, 1000);
        else if (pick < 9)
            t = 32'hffff_ffff - $urandom_range(0, st);   // deadline can wrap past zero
        else
            t = $urandom;
        due = t + 32'(st);
        plan_req(s, OP_POLL, 1'b1, 8'($urandom), t);
        repeat ($urandom_range(0, 3))
            plan_req(s, OP_POLL, 1'b1, 8'($urandom), t + $urandom_range(0, st));
        if ($urandom_range(0, 3) == 0)
            plan_req(s, OP_POLL, 1'b1, CIS_TUPLE_MARK, due);   // exactly at deadline
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                plan_req(s, OP_POLL, 1'b0, 8'($urandom), due);
            else
                plan_req(s, OP_RESET, 1'b1, 8'($urandom), due);
            slot_clock[s] = due;
            return;
        end
        pick = $urandom_range(0, 3);
        if (pick == 0)
            pass_at = due + 1;
        else if (pick == 3)
            pass_at = due + 1 + $urandom_range(0, 32'h7fff_ffff);
        else
            pass_at = due + 1 + $urandom_range(0, 1000);
        mark = CIS_TUPLE_MARK;
        if ($urandom_range(0, 3) == 0)
        begin
            mark = 8'($urandom);
            if (mark == CIS_TUPLE_MARK)
                mark = 8'h00;
        end
        plan_req(s, OP_POLL, 1'b1, mark, pass_at);
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 4) == 0)
                plan_req(s, OP_RESET, 1'b0, 8'($urandom), pass_at);
            else
                plan_req(s, OP_POLL, 1'b1, 8'($urandom), pass_at + $urandom_range(0, 5000));
        end
        pick = $urandom_range(0, 9);
        if (pick < 5)
            plan_req(s, OP_POLL, 1'b0, 8'($urandom), pass_at);
        else if (pick < 8)
            plan_req(s, OP_RESET, 1'b1, 8'($urandom), pass_at);
        slot_clock[s] = pass_at;
    endtask

    // Interleave the per-slot plans, hand them to the driver, then wait
    // until every request has its result and the block has gone quiet.
    task automatic issue_and_drain(input bit eager);
        slot_req_t   r;
        logic        s;
        recv_eager <= eager;
        while (slot_plan[0].size() + slot_plan[1].size() != 0)
        begin
            if (slot_plan[0].size() == 0)
                s = 1'b1;
            else if (slot_plan[1].size() == 0)
                s = 1'b0;
            else
                s = 1'($urandom_range(0, 1));
            r = slot_plan[s].pop_front();
            r.gap = eager ? 0 : $urandom_range(0, 7);
            poll_queue.push_back(r);
            issued_total++;
        end
        do
            @(posedge clk);
        while (accepted_total != issued_total || expected_status.size() != 0);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_settle(input logic [15:0] st);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= st;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        settle_model = st;
    endtask

    task automatic run_phase(input logic [15:0] st, input int n_items,
                             input bit eager, input bit long_hold);
        write_settle(st);
        if (long_hold)
            holds_asked <= holds_asked + 1;
        while (slot_plan[0].size() + slot_plan[1].size() < n_items)
        begin
            if ($urandom_range(0, 99) < 15)
                plan_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 8'($urandom), $urandom);
            else
                plan_insertion(1'($urandom_range(0, 1)), st);
        end
        issue_and_drain(eager);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_model();
        slot_clock[0] = '0;
        slot_clock[1] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests with the settle time left at its reset value.
        // Slot 0: arm, equal-to-deadline poll, pass into ready, ready holds,
        // reset without card, reset with card, deadline wrapping past zero,
        // failed tuple check, removal.
        plan_req(1'b0, OP_POLL,  1'b1, 8'h00, 32'h0000_0000);
        plan_req(1'b0, OP_POLL,  1'b1, 8'h1d, 32'h0000_0032);
        plan_req(1'b0, OP_POLL,  1'b1, 8'h1d, 32'h0000_0033);
        plan_req(1'b0, OP_POLL,  1'b1, 8'h00, 32'h0000_0000);
        plan_req(1'b0, OP_RESET, 1'b0, 8'hff, 32'hffff_ffff);
        plan_req(1'b0, OP_POLL,  1'b1, 8'hff, 32'hffff_ffff);
        plan_req(1'b0, OP_RESET, 1'b1, 8'h00, 32'h0000_0000);
        plan_req(1'b0, OP_POLL,  1'b1, 8'h1d, 32'hffff_fff0);
        plan_req(1'b0, OP_POLL,  1'b1, 8'h1d, 32'h0000_0022);
        plan_req(1'b0, OP_POLL,  1'b1, 8'h1c, 32'h0000_0023);
        plan_req(1'b0, OP_POLL,  1'b1, 8'h1d, 32'h0000_0024);
        plan_req(1'b0, OP_POLL,  1'b0, 8'hff, 32'h0000_0060);
        plan_req(1'b0, OP_POLL,  1'b1, 8'h1d, 32'h0000_0061);
        // Slot 1: half-range distance either side of the compare boundary,
        // removal, resets on an empty slot, an arm whose deadline lands in the upper half.
        plan_req(1'b1, OP_POLL,  1'b1, 8'hff, 32'hffff_ffff);
        plan_req(1'b1, OP_POLL,  1'b1, 8'h1d, 32'h8000_0032);
        plan_req(1'b1, OP_POLL,  1'b1, 8'h1d, 32'h8000_0031);
        plan_req(1'b1, OP_POLL,  1'b0, 8'h00, 32'h0000_0000);
        plan_req(1'b1, OP_RESET, 1'b1, 8'h00, 32'h0000_0000);
        plan_req(1'b1, OP_RESET, 1'b0, 8'hff, 32'hffff_ffff);
        plan_req(1'b1, OP_POLL,  1'b1, 8'h00, 32'h7fff_ffff);
        plan_req(1'b1, OP_POLL,  1'b1, 8'h1d, 32'h8000_0032);
        issue_and_drain(1'b0);

        // Random phases over several settle times; the long hold-off rides
        // on the slowest setting, one phase runs with no idling at all.
        run_phase(16'd1,                        180, 1'b0, 1'b0);
        run_phase(16'd65535,                    180, 1'b0, 1'b1);
        run_phase(16'd0,                        180, 1'b0, 1'b0);
        run_phase(16'($urandom_range(2, 200)),  180, 1'b1, 1'b0);
        run_phase(16'($urandom_range(1, 65535)), 180, 1'b0, 1'b0);
        run_phase(SETTLE_RESET,                 180, 1'b0, 1'b0);

        repeat (DRAIN_PAUSE) @(posedge clk);
        if (expected_status.size() != 0)
        begin
            $error("%0d results never arrived", expected_status.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
